>>> sv/i2p_pkg.sv
// ============================================================================
// i2p_pkg
// Shared types, character codes and priority functions for the
// infix-to-postfix converter.
// ============================================================================
package i2p_pkg;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } i2p_in_t;

  // Result transaction payload
  typedef struct packed {
    logic [7:0] out_symbol;
    logic       has_symbol;
    logic       end_of_expression;
    logic       error;
  } i2p_out_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_OPCHK,
    S_PUSH,
    S_CPCHK,
    S_FLUSH_RD,
    S_FLUSH_EM,
    S_END
  } i2p_state_t;

  // Character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_MUL    = 8'h2A;  // '*'
  localparam logic [7:0] CH_ADD    = 8'h2B;  // '+'
  localparam logic [7:0] CH_SUB    = 8'h2D;  // '-'
  localparam logic [7:0] CH_DIV    = 8'h2F;  // '/'
  localparam logic [7:0] CH_MOD    = 8'h25;  // '%'
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;

  // Priorities
  localparam logic [1:0] PRIO_NONE  = 2'd0;
  localparam logic [1:0] PRIO_ADD   = 2'd1;
  localparam logic [1:0] PRIO_MUL   = 2'd2;
  localparam logic [1:0] PRIO_PAREN = 2'd3;

  function automatic logic is_letter(input logic [7:0] ch);
    return ((ch >= CH_UC_A) && (ch <= CH_UC_Z)) || ((ch >= CH_LC_A) && (ch <= CH_LC_Z));
  endfunction

  function automatic logic is_mul_class(input logic [7:0] ch);
    return (ch == CH_MUL) || (ch == CH_DIV) || (ch == CH_MOD);
  endfunction

  function automatic logic is_add_class(input logic [7:0] ch);
    return (ch == CH_ADD) || (ch == CH_SUB);
  endfunction

  // Priority of an arriving operator or '('
  function automatic logic [1:0] prio_in(input logic [7:0] ch);
    logic [1:0] p;
    p = PRIO_ADD;
    if (ch == CH_LPAREN) begin
      p = PRIO_PAREN;
    end else if (is_mul_class(ch)) begin
      p = PRIO_MUL;
    end
    return p;
  endfunction

  // Priority of an entry already on the stack
  function automatic logic [1:0] prio_stk(input logic [7:0] ch);
    logic [1:0] p;
    p = PRIO_NONE;
    if (is_mul_class(ch)) begin
      p = PRIO_MUL;
    end else if (is_add_class(ch)) begin
      p = PRIO_ADD;
    end
    return p;
  endfunction

endpackage

>>> sv/infix_to_postfix_converter_unit.sv
// ============================================================================
// infix_to_postfix_converter_unit
// Shunting-yard converter: one expression character per input transaction,
// postfix characters out, operator stack held in a synchronous memory.
// ============================================================================
// Sequence: a letter is loaded into the output register as it is accepted. An
// operator on a non-empty stack reads the top, pops in S_OPCHK, then is pushed in
// S_PUSH; a matched ')' pops in S_CPCHK until its '(' is discarded. A final item
// then reads in S_FLUSH_RD, pops each stacked entry in S_FLUSH_EM and emits the
// end marker in S_END. One item is processed at a time; results stall on out_stall.
// Reset (synchronous, rst_n low) empties the stack and clears the error flag.

module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  i2p_pkg::i2p_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output i2p_pkg::i2p_out_t out_data
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO_C   = CNT_W'(2);

  // Operator stack memory
  logic [7:0]        stack_mem [STACK_DEPTH];
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data_r;

  // Control state
  i2p_pkg::i2p_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    paren_r, paren_nxt;
  logic                err_r, err_nxt;

  // Held item
  logic [7:0] sym_r, sym_nxt;
  logic       last_r, last_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  i2p_pkg::i2p_out_t   out_data_r, out_data_nxt;

  logic             out_free;
  logic             in_acc;
  logic             emit;
  logic [7:0]       emit_sym;
  logic             emit_end;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_m2;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == i2p_pkg::S_IDLE) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cnt_m1    = count_r - ONE_C;
  assign cnt_m2    = count_r - TWO_C;

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  // Sequencer: next state, memory accesses and emitted results
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    paren_nxt = paren_r;
    err_nxt   = err_r;
    sym_nxt   = sym_r;
    last_nxt  = last_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = sym_r;
    rd_en     = 1'b0;
    rd_addr   = cnt_m1[ADDR_W-1:0];
    emit      = 1'b0;
    emit_sym  = 8'h00;
    emit_end  = 1'b0;

    case (state_r)
      i2p_pkg::S_IDLE: begin
        if (in_acc) begin
          // Capture the transaction and classify the character
          sym_nxt  = in_data.symbol;
          last_nxt = in_data.last;
          state_nxt = in_data.last ? i2p_pkg::S_FLUSH_RD : i2p_pkg::S_IDLE;
          if (i2p_pkg::is_letter(in_data.symbol)) begin
            emit     = 1'b1;
            emit_sym = in_data.symbol;
          end else if (i2p_pkg::is_mul_class(in_data.symbol) ||
                       i2p_pkg::is_add_class(in_data.symbol) ||
                       (in_data.symbol == i2p_pkg::CH_LPAREN)) begin
            if (count_r == '0) begin
              // Empty stack: push straight away
              wr_en     = 1'b1;
              wr_addr   = '0;
              wr_data   = in_data.symbol;
              count_nxt = ONE_C;
              if (in_data.symbol == i2p_pkg::CH_LPAREN) begin
                paren_nxt = paren_r + ONE_C;
              end
            end else begin
              rd_en     = 1'b1;
              state_nxt = i2p_pkg::S_OPCHK;
            end
          end else if (in_data.symbol == i2p_pkg::CH_RPAREN) begin
            if (paren_r == '0) begin
              err_nxt = 1'b1;
            end else begin
              rd_en     = 1'b1;
              state_nxt = i2p_pkg::S_CPCHK;
            end
          end else begin
            err_nxt = 1'b1;
          end
        end
      end

      i2p_pkg::S_OPCHK: begin
        if (i2p_pkg::prio_stk(rd_data_r) >= i2p_pkg::prio_in(sym_r)) begin
          // Pop the top entry once the output register is free
          if (out_free) begin
            emit      = 1'b1;
            emit_sym  = rd_data_r;
            count_nxt = cnt_m1;
            if (cnt_m1 == '0) begin
              state_nxt = i2p_pkg::S_PUSH;
            end else begin
              rd_en   = 1'b1;
              rd_addr = cnt_m2[ADDR_W-1:0];
            end
          end
        end else begin
          state_nxt = i2p_pkg::S_PUSH;
        end
      end

      i2p_pkg::S_PUSH: begin
        if (count_r < DEPTH_C) begin
          wr_en     = 1'b1;
          wr_addr   = count_r[ADDR_W-1:0];
          count_nxt = count_r + ONE_C;
          if (sym_r == i2p_pkg::CH_LPAREN) begin
            paren_nxt = paren_r + ONE_C;
          end
        end else begin
          // Overflow: drop the operator
          err_nxt = 1'b1;
        end
        state_nxt = last_r ? i2p_pkg::S_FLUSH_RD : i2p_pkg::S_IDLE;
      end

      i2p_pkg::S_CPCHK: begin
        if (rd_data_r == i2p_pkg::CH_LPAREN) begin
          // Discard the matching '('
          count_nxt = cnt_m1;
          paren_nxt = paren_r - ONE_C;
          state_nxt = last_r ? i2p_pkg::S_FLUSH_RD : i2p_pkg::S_IDLE;
        end else if (out_free) begin
          // A '(' lies below, so the stack cannot run empty here
          emit      = 1'b1;
          emit_sym  = rd_data_r;
          count_nxt = cnt_m1;
          rd_en     = 1'b1;
          rd_addr   = cnt_m2[ADDR_W-1:0];
        end
      end

      i2p_pkg::S_FLUSH_RD: begin
        if (count_r == '0) begin
          state_nxt = i2p_pkg::S_END;
        end else begin
          rd_en     = 1'b1;
          state_nxt = i2p_pkg::S_FLUSH_EM;
        end
      end

      i2p_pkg::S_FLUSH_EM: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_sym  = rd_data_r;
          count_nxt = cnt_m1;
          // A leftover '(' leaves the stack here, so drop it from the count
          if (rd_data_r == i2p_pkg::CH_LPAREN) begin
            paren_nxt = paren_r - ONE_C;
          end
          if (cnt_m1 == '0) begin
            state_nxt = i2p_pkg::S_END;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cnt_m2[ADDR_W-1:0];
          end
        end
      end

      i2p_pkg::S_END: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_end  = 1'b1;
          paren_nxt = '0;
          state_nxt = i2p_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = i2p_pkg::S_IDLE;
      end
    endcase
  end

  // Output register: load on emit, drop once taken
  always_comb begin
    out_data_nxt = out_data_r;
    if (emit) begin
      out_valid_nxt                  = 1'b1;
      out_data_nxt.out_symbol        = emit_sym;
      out_data_nxt.has_symbol        = !emit_end;
      out_data_nxt.end_of_expression = emit_end;
      out_data_nxt.error             = err_r;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i2p_pkg::S_IDLE;
      count_r     <= '0;
      paren_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      paren_r     <= paren_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  // Stack occupancy stays within the memory
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("stack count beyond depth");

  // Open parens on the stack never outnumber stacked entries
  a_paren_bound: assert property (@(posedge clk) disable iff (!rst_n)
    paren_r <= count_r)
    else $error("open paren count exceeds stack count");

  // No read and write of the same entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en && (wr_addr == rd_addr)))
    else $error("stack read and write collide");

  // Error flag is sticky until reset
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r)
    else $error("error flag cleared");

  // The end marker leaves an empty stack
  a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_end) |-> (count_r == '0))
    else $error("end marker with stacked entries");

endmodule
